// ===== design/moving_average_with_deviation_macros.svh =====
// Assertion helpers for the checker file of the moving average block.
`ifndef MOVING_AVERAGE_WITH_DEVIATION_MACROS_SVH
`define MOVING_AVERAGE_WITH_DEVIATION_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving average check failed");

// Check a condition in the cycle after its trigger.
`define MAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving average check failed");

`endif

// ===== design/mad_pkg.sv =====
package mad_pkg;

   // Register and port widths, window reset value and defaults fixed by the register map
   localparam int WIN_BITS            = 7;
   localparam int WINDOW_RESET        = 64;
   localparam int MAX_WINDOW_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_WINDOW = 1'b0,
      CSR_SIGMA  = 1'b1
   } csr_index_type;

   // Request kinds
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_SUM,
      ST_DIV_MEAN,
      ST_MEAN,
      ST_SQUARE,
      ST_SQSUM,
      ST_DIV_SQ,
      ST_ROOT,
      ST_NEXT,
      ST_OUT
   } state_type;

endpackage

// ===== design/moving_average_with_deviation.sv =====
// Moving average with rolling deviation. Each request word either pushes a signed
// fixed-point sample into a ring of the last window_length samples, answering with
// the window mean (truncated toward zero, saturated), sigma (floor square root of the
// mean squared deviation, 0 unless sigma_enable is set) and the sample that will be
// replaced next, or clears the ring to a fill value with no response. Work goes
// through one shared restoring divider of width DW (one quotient bit per cycle)
// and a bit-pair square root unit, DW being 2*SAMPLE_BITS + log2(MAX_WINDOW)
// (38 by default). A push holds req_ready low through the mean division, and with
// sigma on through the square division and the root, until its response enters
// the output register; a response still waiting there delays this until it is
// taken, so no new word is taken before the last push is done. A clear, and the
// start after reset, sweep all MAX_WINDOW ring entries one per cycle with
// req_ready low; csr writes are taken at any time and must only be issued while
// the block is idle. A finished response waits in an output register, so the
// next request word is taken while it is still pending.
module moving_average_with_deviation #(
   parameter int MAX_WINDOW  = mad_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = mad_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  mad_pkg::csr_index_type        csr_index,
   input  logic [mad_pkg::WIN_BITS-1:0]  csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_mean,
   output logic        [SAMPLE_BITS-1:0] rsp_sigma,
   output logic signed [SAMPLE_BITS-1:0] rsp_oldest
);
   import mad_pkg::*;

   localparam int S          = SAMPLE_BITS;
   localparam int IDX_BITS   = $clog2(MAX_WINDOW);
   localparam int SUM_BITS   = S + IDX_BITS + 1;
   localparam int SQ_BITS    = 2 * S;
   localparam int SQSUM_BITS = SQ_BITS + IDX_BITS;
   localparam int DW         = SQSUM_BITS;
   localparam int CW         = (WIN_BITS > IDX_BITS + 1) ? WIN_BITS : IDX_BITS + 1;
   localparam int CNT_BITS   = $clog2((DW > MAX_WINDOW) ? DW : MAX_WINDOW);
   localparam int ROOT_TOP   = 2 * ((DW - 1) / 2);

   localparam logic [S-1:0]  SMAX   = {1'b0, {(S-1){1'b1}}};
   localparam logic [S-1:0]  SMIN   = {1'b1, {(S-1){1'b0}}};
   localparam logic [DW-1:0] SMAX_Q = {{(DW-S+1){1'b0}}, {(S-1){1'b1}}};
   localparam logic [DW-1:0] SMIN_Q = {{(DW-S){1'b0}}, 1'b1, {(S-1){1'b0}}};

   // Ring memories
   logic [S-1:0]       sample_mem [MAX_WINDOW];
   logic [SQ_BITS-1:0] square_mem [MAX_WINDOW];

   // Registers
   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [S-1:0]            x_ff, x_in;
   logic [IDX_BITS-1:0]     k_ff, k_in;
   logic [S-1:0]            fill_ff, fill_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SQSUM_BITS-1:0]   sqsum_ff, sqsum_in;
   logic [IDX_BITS-1:0]     widx_ff, widx_in;
   logic [WIN_BITS-1:0]     window_ff;
   logic                    sigma_en_ff;
   logic                    neg_ff, neg_in;
   logic [CW-1:0]           div_rem_ff, div_rem_in;
   logic [DW-1:0]           div_quo_ff, div_quo_in;
   logic [S-1:0]            mean_ff, mean_in;
   logic [SQ_BITS-1:0]      sq_ff, sq_in;
   logic [DW-1:0]           root_x_ff, root_x_in;
   logic [DW-1:0]           root_res_ff, root_res_in;
   logic [DW-1:0]           root_bit_ff, root_bit_in;
   logic [S-1:0]            sigma_ff, sigma_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]            rsp_mean_ff, rsp_mean_in;
   logic [S-1:0]            rsp_sigma_ff, rsp_sigma_in;
   logic [S-1:0]            rsp_oldest_ff, rsp_oldest_in;
   logic [S-1:0]            sample_rd_ff;
   logic [SQ_BITS-1:0]      square_rd_ff;

   // Memory port controls
   logic                    smem_we, qmem_we, rd_en;
   logic [IDX_BITS-1:0]     smem_waddr, qmem_waddr, rd_addr;
   logic [S-1:0]            smem_wdata;
   logic [SQ_BITS-1:0]      qmem_wdata;

   // Datapath nets
   logic [CW-1:0]           w_eff;
   logic [IDX_BITS-1:0]     k_cur;
   logic [IDX_BITS:0]       k_inc;
   logic [IDX_BITS-1:0]     k_next;
   logic signed [S+CW:0]    fill_prod;
   logic [SUM_BITS-1:0]     sum_new, sum_mag;
   logic [CW:0]             div_trial;
   logic                    div_ge;
   logic [CW-1:0]           div_rem_step;
   logic [DW-1:0]           div_quo_step;
   logic                    div_last;
   logic [DW-1:0]           quo_neg;
   logic signed [S:0]       diff;
   logic [S:0]              diff_abs;
   logic [S-1:0]            ad;
   logic [SQ_BITS-1:0]      sq_prod;
   logic [SQSUM_BITS-1:0]   sqsum_new;
   logic [DW:0]             root_trial;
   logic                    root_ge;
   logic [DW-1:0]           root_x_step, root_res_step, root_bit_step;
   logic [S-1:0]            root_sat;

   // Clamp the window to 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         w_eff = CW'(1);
      end else if (CW'(window_ff) > CW'(MAX_WINDOW)) begin
         w_eff = CW'(MAX_WINDOW);
      end else begin
         w_eff = CW'(window_ff);
      end
   end

   // Ring positions: current slot and the one after it
   assign k_cur  = (CW'(widx_ff) >= w_eff) ? '0 : widx_ff;
   assign k_inc  = {1'b0, k_ff} + (IDX_BITS+1)'(1);
   assign k_next = (CW'(k_inc) >= w_eff) ? '0 : k_inc[IDX_BITS-1:0];

   // Running sum after a clear and after a push
   assign fill_prod = $signed(x_in) * $signed({1'b0, w_eff});
   assign sum_new   = sum_ff - SUM_BITS'($signed(sample_rd_ff)) + SUM_BITS'($signed(x_ff));
   assign sum_mag   = sum_new[SUM_BITS-1] ? -sum_new : sum_new;

   // Shared divider: one restoring step per cycle
   assign div_trial    = {div_rem_ff, div_quo_ff[DW-1]};
   assign div_ge       = div_trial >= {1'b0, w_eff};
   assign div_rem_step = div_ge ? CW'(div_trial - {1'b0, w_eff}) : div_trial[CW-1:0];
   assign div_quo_step = {div_quo_ff[DW-2:0], div_ge};
   assign div_last     = cnt_ff == CNT_BITS'(DW - 1);
   assign quo_neg      = -div_quo_ff;

   // Squared deviation of the saturated mean from the sample
   assign diff     = $signed({mean_ff[S-1], mean_ff}) - $signed({x_ff[S-1], x_ff});
   assign diff_abs = diff[S] ? -diff : diff;
   assign ad       = diff_abs[S-1:0];
   assign sq_prod  = SQ_BITS'(ad) * SQ_BITS'(ad);
   assign sqsum_new = sqsum_ff - SQSUM_BITS'(square_rd_ff) + SQSUM_BITS'(sq_ff);

   // Square root: one bit pair per cycle
   assign root_trial    = {1'b0, root_res_ff} + {1'b0, root_bit_ff};
   assign root_ge       = {1'b0, root_x_ff} >= root_trial;
   assign root_x_step   = root_ge ? root_x_ff - root_trial[DW-1:0] : root_x_ff;
   assign root_res_step = root_ge ? (root_res_ff >> 1) + root_bit_ff : root_res_ff >> 1;
   assign root_bit_step = root_bit_ff >> 2;
   assign root_sat      = (|root_res_step[DW-1:S]) ? '1 : root_res_step[S-1:0];

   assign req_ready = state_ff == ST_IDLE;

   // Sequencer: next state, datapath loads and memory ports
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      k_in          = k_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      sqsum_in      = sqsum_ff;
      widx_in       = widx_ff;
      neg_in        = neg_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      mean_in       = mean_ff;
      sq_in         = sq_ff;
      root_x_in     = root_x_ff;
      root_res_in   = root_res_ff;
      root_bit_in   = root_bit_ff;
      sigma_in      = sigma_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_sigma_in  = rsp_sigma_ff;
      rsp_oldest_in = rsp_oldest_ff;
      smem_we       = 1'b0;
      smem_waddr    = k_ff;
      smem_wdata    = x_ff;
      qmem_we       = 1'b0;
      qmem_waddr    = k_ff;
      qmem_wdata    = sq_ff;
      rd_en         = 1'b0;
      rd_addr       = k_cur;

      unique case (state_ff)
         ST_FILL: begin
            // Sweep every slot with the fill value
            smem_we    = 1'b1;
            smem_waddr = cnt_ff[IDX_BITS-1:0];
            smem_wdata = fill_ff;
            qmem_we    = 1'b1;
            qmem_waddr = cnt_ff[IDX_BITS-1:0];
            qmem_wdata = '0;
            cnt_in     = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(MAX_WINDOW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Read the current slot; take the word
            rd_en = 1'b1;
            x_in  = req_sample;
            if (req_valid) begin
               k_in = k_cur;
               if (req_kind == KIND_CLEAR) begin
                  fill_in  = req_sample;
                  sum_in   = fill_prod[SUM_BITS-1:0];
                  sqsum_in = '0;
                  widx_in  = '0;
                  cnt_in   = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // Update the sum, store the sample, start the mean division
            sum_in     = sum_new;
            smem_we    = 1'b1;
            neg_in     = sum_new[SUM_BITS-1];
            div_rem_in = '0;
            div_quo_in = DW'(sum_mag);
            cnt_in     = '0;
            state_in   = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            cnt_in     = cnt_ff + CNT_BITS'(1);
            if (div_last) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            // Restore the sign and saturate
            if (neg_ff) begin
               mean_in = (div_quo_ff > SMIN_Q) ? SMIN : quo_neg[S-1:0];
            end else begin
               mean_in = (div_quo_ff > SMAX_Q) ? SMAX : div_quo_ff[S-1:0];
            end
            if (sigma_en_ff) begin
               state_in = ST_SQUARE;
            end else begin
               sigma_in = '0;
               state_in = ST_NEXT;
            end
         end
         ST_SQUARE: begin
            sq_in    = sq_prod;
            state_in = ST_SQSUM;
         end
         ST_SQSUM: begin
            // Update the square sum, store the square, start the second division
            sqsum_in   = sqsum_new;
            qmem_we    = 1'b1;
            div_rem_in = '0;
            div_quo_in = sqsum_new;
            cnt_in     = '0;
            state_in   = ST_DIV_SQ;
         end
         ST_DIV_SQ: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            cnt_in     = cnt_ff + CNT_BITS'(1);
            if (div_last) begin
               root_x_in   = div_quo_step;
               root_res_in = '0;
               root_bit_in = DW'(1) << ROOT_TOP;
               state_in    = ST_ROOT;
            end
         end
         ST_ROOT: begin
            root_x_in   = root_x_step;
            root_res_in = root_res_step;
            root_bit_in = root_bit_step;
            if (root_bit_step == '0) begin
               sigma_in = root_sat;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // Advance the write position and read the new oldest sample
            widx_in  = k_next;
            rd_en    = 1'b1;
            rd_addr  = k_next;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the word to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_sigma_in  = sigma_ff;
               rsp_oldest_in = sample_rd_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         widx_ff      <= widx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WIN_BITS'(WINDOW_RESET);
         sigma_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: window_ff   <= csr_data;
            CSR_SIGMA:  sigma_en_ff <= csr_data[0];
            default:    window_ff   <= window_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      k_ff          <= k_in;
      neg_ff        <= neg_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      mean_ff       <= mean_in;
      sq_ff         <= sq_in;
      root_x_ff     <= root_x_in;
      root_res_ff   <= root_res_in;
      root_bit_ff   <= root_bit_in;
      sigma_ff      <= sigma_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_sigma_ff  <= rsp_sigma_in;
      rsp_oldest_ff <= rsp_oldest_in;
   end

   // Ring memories: one write port each, shared read address with registered read data
   always_ff @(posedge clock) begin
      if (smem_we) begin
         sample_mem[smem_waddr] <= smem_wdata;
      end
      if (qmem_we) begin
         square_mem[qmem_waddr] <= qmem_wdata;
      end
      if (rd_en) begin
         sample_rd_ff <= sample_mem[rd_addr];
         square_rd_ff <= square_mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mean   = rsp_mean_ff;
   assign rsp_sigma  = rsp_sigma_ff;
   assign rsp_oldest = rsp_oldest_ff;

endmodule

// ===== design/mad_checker.sv =====
`include "moving_average_with_deviation_macros.svh"

module mad_checker #(
   parameter int SAMPLE_BITS = mad_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_mean,
   input logic [SAMPLE_BITS-1:0] rsp_sigma,
   input logic [SAMPLE_BITS-1:0] rsp_oldest
);

   // Hold a stalled response word
   `MAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MAD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_mean) && $stable(rsp_sigma) && $stable(rsp_oldest))

   // Stay busy after taking a request word
   `MAD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // Sweep the rings before the first request after reset
   `MAD_ASSERT_IMPL(a_sweep_after_reset, clock, reset, $fell(reset), !req_ready)

endmodule

bind moving_average_with_deviation mad_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_mad_checker (.*);

// ===== sim/moving_average_with_deviation_tb.sv =====
module moving_average_with_deviation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mad_pkg::*;

   typedef struct {
      logic signed [15:0] mean;
      logic        [15:0] sigma;
      logic signed [15:0] oldest;
   } avg_word_type;

   // Tracks the sample window and squared deviations, queues the expected response words
   class avg_scoreboard;
      logic signed [15:0] sample_hist [64];
      logic        [31:0] dev_sq_hist [64];
      logic signed [22:0] sample_total;
      logic        [37:0] dev_sq_total;
      int unsigned        slot;
      logic        [6:0]  window_reg;
      logic               sigma_on;
      avg_word_type       expected_q [$];
      int                 mismatches;
      int                 checked;

      function new();
         foreach (sample_hist[i]) begin
            sample_hist[i] = '0;
            dev_sq_hist[i] = '0;
         end
         sample_total = '0;
         dev_sq_total = '0;
         slot         = 0;
         window_reg   = 7'd64;
         sigma_on     = 1'b0;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [6:0] val);
         if (idx == CSR_WINDOW) begin
            window_reg = val;
         end else begin
            sigma_on = val[0];
         end
      endfunction

      // Zero acts as one, anything past the ring depth acts as the full ring
      function int unsigned eff_window();
         if (window_reg == 0) return 1;
         if (window_reg > 64) return 64;
         return 32'(window_reg);
      endfunction

      function longint unsigned floor_sqrt(longint unsigned x);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = 19; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
         end
         return r;
      endfunction

      // Advance the window by one accepted request word
      function void note_word(logic kind, logic signed [15:0] smp);
         int unsigned     w;
         int unsigned     k;
         longint          total;
         longint          avg;
         longint          diff;
         longint unsigned mag;
         longint unsigned sq;
         longint unsigned root;
         avg_word_type    res;
         w = eff_window();
         k = slot;
         if (k >= w) k = 0;
         if (kind == KIND_CLEAR) begin
            foreach (sample_hist[i]) begin
               sample_hist[i] = smp;
               dev_sq_hist[i] = '0;
            end
            total        = longint'(smp) * longint'(w);
            sample_total = total[22:0];
            dev_sq_total = '0;
            slot         = 0;
            return;
         end
         // Swap the sample in its slot; the sum wraps at its own width
         total        = longint'(sample_total) - longint'(sample_hist[k]) + longint'(smp);
         sample_total = total[22:0];
         sample_hist[k] = smp;
         avg = longint'(sample_total) / longint'(w);
         if (avg > 32767) avg = 32767;
         if (avg < -32768) avg = -32768;
         res.sigma = '0;
         if (sigma_on) begin
            diff = avg - longint'(smp);
            mag  = (diff < 0) ? -diff : diff;
            sq   = (mag * mag) & 64'hFFFF_FFFF;
            dev_sq_total   = 38'(dev_sq_total - dev_sq_hist[k] + sq);
            dev_sq_hist[k] = sq[31:0];
            root = floor_sqrt(64'(dev_sq_total) / 64'(w));
            res.sigma = (root > 65535) ? 16'hFFFF : root[15:0];
         end
         res.mean = avg[15:0];
         k = k + 1;
         if (k >= w) k = 0;
         slot = k;
         res.oldest = sample_hist[k];
         expected_q.push_back(res);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one response word against the oldest expectation
      task check_word(avg_word_type got);
         avg_word_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response word mean=%0d sigma=%0d oldest=%0d with none pending",
                             got.mean, got.sigma, got.oldest));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.mean !== want.mean)
            report($sformatf("word %0d mean got %0d want %0d", checked, got.mean, want.mean));
         if (got.sigma !== want.sigma)
            report($sformatf("word %0d sigma got %0d want %0d", checked, got.sigma, want.sigma));
         if (got.oldest !== want.oldest)
            report($sformatf("word %0d oldest got %0d want %0d",
                             checked, got.oldest, want.oldest));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_we      = 1'b0;
   csr_index_type        csr_index   = CSR_WINDOW;
   logic [WIN_BITS-1:0]  csr_data    = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic                 req_kind    = KIND_PUSH;
   logic signed [15:0]   req_sample  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic signed [15:0]   rsp_mean;
   logic        [15:0]   rsp_sigma;
   logic signed [15:0]   rsp_oldest;

   avg_scoreboard sb = new();
   bit            steady = 1'b0;
   int            hold_request = 0;
   int            push_count = 0;
   int            clear_count = 0;
   int            setting_count = 0;

   moving_average_with_deviation DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mean   (rsp_mean),
      .rsp_sigma  (rsp_sigma),
      .rsp_oldest (rsp_oldest)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request word, with an occasional idle gap first, and hold it until taken
   task automatic send_word(logic kind, logic signed [15:0] smp);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sample <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(kind, smp);
      if (kind == KIND_CLEAR) clear_count++;
      else push_count++;
   endtask

   // Drop valid and wait until every expected word is back, then let a clear sweep finish
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [6:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      setting_count++;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] next_sample(int level);
      int v;
      case ($urandom_range(9))
         0, 1: return 16'($urandom);
         2: begin
            case ($urandom_range(3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: begin
            v = level + int'($urandom_range(1023)) - 512;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
         end
      endcase
   endfunction

   // Response side: take words, randomly stall, and run the long hold when asked
   initial begin
      int           hold_left;
      avg_word_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.mean   = rsp_mean;
            got.sigma  = rsp_sigma;
            got.oldest = rsp_oldest;
            sb.check_word(got);
         end
         if (hold_request != 0) begin
            hold_request = 0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && (steady || $urandom_range(99) >= 8);
         end
      end
   end

   initial begin
      logic [6:0] win_table [12];
      logic [6:0] win;
      logic       sig;
      int         level;
      win_table = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd33,
                    7'd64, 7'd3, 7'd65, 7'd16, 7'd8, 7'd64};
      level = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: extremes through a full window, oldest still zero
      send_word(KIND_PUSH, 16'sh7FFF);
      send_word(KIND_PUSH, 16'sh8000);
      send_word(KIND_PUSH, 16'sh0000);
      send_word(KIND_PUSH, 16'shFFFF);
      send_word(KIND_PUSH, 16'sh0001);

      // Turn on sigma mid-window without a clear
      wait_drained();
      write_csr(CSR_SIGMA, 7'd1);
      send_word(KIND_PUSH, 16'sh5555);
      send_word(KIND_PUSH, 16'shAAAA);

      // Shrink the window with no clear: write position past the window restarts
      wait_drained();
      write_csr(CSR_WINDOW, 7'd1);
      send_word(KIND_PUSH, 16'sh7FFF);
      send_word(KIND_PUSH, 16'sh8000);
      send_word(KIND_CLEAR, 16'sh8000);
      send_word(KIND_PUSH, 16'sh7FFF);

      // Zero window behaves as one
      wait_drained();
      write_csr(CSR_WINDOW, 7'd0);
      send_word(KIND_PUSH, 16'sh0064);

      // Oversized window acts as full ring; clear at the top value
      wait_drained();
      write_csr(CSR_WINDOW, 7'd127);
      send_word(KIND_CLEAR, 16'sh7FFF);
      send_word(KIND_PUSH, 16'sh8000);

      // Narrow the window over a large sum so the mean saturates
      wait_drained();
      write_csr(CSR_WINDOW, 7'd2);
      send_word(KIND_PUSH, 16'sh7FFF);
      send_word(KIND_PUSH, 16'sh8000);

      // Only bit zero of the sigma register counts
      wait_drained();
      write_csr(CSR_SIGMA, 7'h7E);
      send_word(KIND_PUSH, 16'sh0000);

      // Random phases: mostly clear followed by pushes, some drifting without a clear
      for (int p = 0; p < 12; p++) begin
         wait_drained();
         win = win_table[p];
         if (p == 6 || p == 10) win = 7'($urandom_range(127));
         sig = (p % 3 != 1);
         write_csr(CSR_WINDOW, win);
         write_csr(CSR_SIGMA, {6'($urandom), sig});
         steady = (p == 2);
         level  = int'($urandom_range(65535)) - 32768;
         if (p % 4 != 3) send_word(KIND_CLEAR, next_sample(level));
         for (int n = 0; n < 90; n++) begin
            if (p == 4 && n == 20) hold_request = 1;
            if (p == 7 && n == 45) wait_drained();
            if ($urandom_range(99) < 10) level = int'($urandom_range(65535)) - 32768;
            if ($urandom_range(99) < 4) send_word(KIND_CLEAR, next_sample(level));
            else send_word(KIND_PUSH, next_sample(level));
         end
         steady = 1'b0;
      end

      // Let everything come back, then linger for anything stray
      wait_drained();
      repeat (200) @(posedge clock);
      while (sb.pending() != 0) begin
         void'(sb.expected_q.pop_front());
         sb.report("expected response word never arrived");
      end

      $display("Sent %0d pushes and %0d clears across %0d register writes.",
               push_count, clear_count, setting_count);
      $display("Checked %0d response words, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("Timeout with %0d words still expected.", sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
